[rtl/core/dtrim_pkg.sv]
// dtrim_pkg: constants, register indexes and shared types for the distance drive
// with heading trim. No dependencies; dtrim_wheel, dtrim_heading and the core import it.
`default_nettype none

package dtrim_pkg;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_COUNTS_PER_CELL = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_RPM         = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STOP_THRESHOLD  = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // reset values of the registers
  localparam logic [15:0] CPC_RESET      = 16'd1000;
  localparam logic [9:0]  MAX_RPM_RESET  = 10'd200;
  localparam logic [15:0] STOP_THR_RESET = 16'd20;

  // control constants
  localparam logic [32:0] DEADBAND      = 33'd50;
  localparam logic [9:0]  BANG_RPM      = 10'd150;
  localparam logic [6:0]  RPM_SCALE     = 7'd100;    // rpm to hundredths of rpm
  localparam logic [16:0] HALF_TURN_CD  = 17'd18000;
  localparam logic signed [17:0] FULL_TURN_CD = 18'sd36000;
  localparam logic signed [18:0] TRIM_CAP_C   = 19'sd10000;  // 100 rpm in hundredths

  localparam int unsigned DistW = 20;   // cell_count times counts_per_cell
  localparam int unsigned CmdW  = 17;

  // per-wheel status handed from the wheel unit to the result logic
  typedef struct packed {
    logic               halt;
    logic signed [15:0] base_c;   // base command in hundredths of rpm
  } wheel_stat_t;

endpackage

`default_nettype wire

[rtl/core/dtrim_in_if.sv]
// dtrim_in_if: input channel (start and tick words) with valid/ready handshake.
// No dependencies.
`default_nettype none

interface dtrim_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         cell_count;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic signed [15:0] yaw_now;
  logic signed [15:0] heading_goal;

  modport source (output valid, kind, cell_count, left_count, right_count, yaw_now,
                  heading_goal, input ready);
  modport sink   (input valid, kind, cell_count, left_count, right_count, yaw_now,
                  heading_goal, output ready);
endinterface

`default_nettype wire

[rtl/core/dtrim_out_if.sv]
// dtrim_out_if: result channel (wheel commands and flags) with valid/ready handshake.
// No dependencies.
`default_nettype none

interface dtrim_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] left_cmd;
  logic signed [16:0] right_cmd;
  logic               left_halt;
  logic               right_halt;
  logic               done_res;
  logic               active;

  modport source (output valid, left_cmd, right_cmd, left_halt, right_halt, done_res,
                  active, input ready);
  modport sink   (input valid, left_cmd, right_cmd, left_halt, right_halt, done_res,
                  active, output ready);
endinterface

`default_nettype wire

[rtl/core/dtrim_wheel.sv]
// dtrim_wheel: one wheel's saturated start target, bang-bang base command and halt flag.
// Depends on dtrim_pkg.
`default_nettype none

module dtrim_wheel (
  input  wire logic signed [31:0]            count,
  input  wire logic signed [31:0]            target_r,
  input  wire logic [dtrim_pkg::DistW-1:0]   travel,
  input  wire logic [9:0]                    max_rpm,
  input  wire logic [15:0]                   stop_thr,
  output logic signed [31:0]                 target_nxt,
  output dtrim_pkg::wheel_stat_t             stat
);
  import dtrim_pkg::*;

  logic signed [32:0] sum;
  logic signed [32:0] err;
  logic [32:0]        mag;
  logic [7:0]         lim;
  logic [13:0]        base_mag;

  // start: count plus travel, saturate on positive overflow
  assign sum        = {count[31], count} + 33'(travel);
  assign target_nxt = (sum[32] != sum[31]) ? 32'sh7FFF_FFFF : sum[31:0];

  // tick: exact 33-bit error, never wraps
  assign err = {target_r[31], target_r} - {count[31], count};
  assign mag = err[32] ? 33'(-err) : 33'(err);

  assign lim      = (max_rpm < BANG_RPM) ? max_rpm[7:0] : BANG_RPM[7:0];
  assign base_mag = 14'(lim) * 14'(RPM_SCALE);

  always_comb begin
    stat.halt = (mag < 33'(stop_thr));
    if (mag < DEADBAND) begin
      stat.base_c = 16'sd0;
    end else if (err[32]) begin
      stat.base_c = -$signed({2'b00, base_mag});
    end else begin
      stat.base_c = $signed({2'b00, base_mag});
    end
  end

endmodule

`default_nettype wire

[rtl/core/dtrim_heading.sv]
// dtrim_heading: wrapped heading error in centidegrees, signed.
// Depends on dtrim_pkg.
`default_nettype none

module dtrim_heading (
  input  wire logic signed [15:0] yaw_now,
  input  wire logic signed [15:0] heading_r,
  output logic signed [17:0]      head_err
);
  import dtrim_pkg::*;

  logic signed [16:0] diff;
  logic [16:0]        ad;
  logic               big;
  logic signed [17:0] ew;
  logic               neg;

  assign diff = {yaw_now[15], yaw_now} - {heading_r[15], heading_r};
  assign ad   = diff[16] ? 17'(-diff) : 17'(diff);
  assign big  = (ad > HALF_TURN_CD);
  // fold across the half turn; out-of-range headings may go negative here
  assign ew   = big ? (FULL_TURN_CD - $signed({1'b0, ad})) : $signed({1'b0, ad});
  // negative when yaw is not above target, flipped after a fold
  assign neg  = (diff[16] || (diff == 17'sd0)) ^ big;
  assign head_err = neg ? -ew : ew;

endmodule

`default_nettype wire

[rtl/core/distance_drive_heading_trim_core.sv]
// distance_drive_heading_trim_core: top level of the distance drive with heading trim.
// Depends on dtrim_pkg, dtrim_in_if, dtrim_out_if, dtrim_wheel and dtrim_heading.
//
//   channel  | dir | handshake            | word
//   in_ch    | in  | valid/ready          | kind, cell_count, counts, yaw, heading goal
//   out_ch   | out | valid/ready          | wheel commands, halt flags, done, active
//   cfg_*    | in  | cfg_we, no back-read | counts_per_cell, max_rpm, stop_threshold
//
// Each accepted word waits in the input register while the wheel and heading logic
// work on it, then moves to the result register once out_ch can take a new result.
// A new word is accepted every cycle while out_ch takes results; a stalled result
// holds the result register and the input register fills, then in_ch.ready drops.
// Reset (synchronous rst_n) clears targets, the moving flag and register defaults.
`default_nettype none

module distance_drive_heading_trim_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  dtrim_in_if.sink                            in_ch,
  dtrim_out_if.source                         out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [dtrim_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [dtrim_pkg::CfgDataW-1:0] cfg_wdata
);
  import dtrim_pkg::*;

  // configuration registers
  logic [15:0] cpc_r;
  logic [9:0]  max_rpm_r;
  logic [15:0] stop_thr_r;

  // move state
  logic signed [31:0] left_target_r, right_target_r;
  logic signed [15:0] heading_r;
  logic               moving_r;

  // input register
  logic               s1_v_r;
  logic               s1_kind_r;
  logic [3:0]         s1_cell_r;
  logic signed [31:0] s1_left_r, s1_right_r;
  logic signed [15:0] s1_yaw_r, s1_goal_r;

  // result register
  logic               out_v_r;
  logic signed [16:0] lcmd_r, rcmd_r;
  logic               lhalt_r, rhalt_r, done_r, active_r;

  logic               adv;
  logic               in_take;
  logic [DistW-1:0]   travel;
  logic signed [31:0] left_target_nxt, right_target_nxt;
  wheel_stat_t        lstat, rstat;
  logic signed [17:0] head_err;
  logic signed [18:0] ltrim, rtrim;
  logic signed [18:0] lsum, rsum;
  logic               tick_live;

  logic signed [16:0] lcmd_nxt, rcmd_nxt;
  logic               lhalt_nxt, rhalt_nxt, done_nxt, active_nxt, moving_nxt;

  assign adv          = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || adv;
  assign in_take      = in_ch.valid && in_ch.ready;

  assign travel = DistW'(s1_cell_r) * DistW'(cpc_r);

  dtrim_wheel u_left (
    .count      (s1_left_r),
    .target_r   (left_target_r),
    .travel     (travel),
    .max_rpm    (max_rpm_r),
    .stop_thr   (stop_thr_r),
    .target_nxt (left_target_nxt),
    .stat       (lstat)
  );

  dtrim_wheel u_right (
    .count      (s1_right_r),
    .target_r   (right_target_r),
    .travel     (travel),
    .max_rpm    (max_rpm_r),
    .stop_thr   (stop_thr_r),
    .target_nxt (right_target_nxt),
    .stat       (rstat)
  );

  dtrim_heading u_heading (
    .yaw_now   (s1_yaw_r),
    .heading_r (heading_r),
    .head_err  (head_err)
  );

  // trim: left takes off the error, right adds it; cap each at base plus 100 rpm
  always_comb begin
    ltrim = -$signed({head_err[17], head_err});
    rtrim = $signed({head_err[17], head_err});
    if (ltrim > TRIM_CAP_C) ltrim = TRIM_CAP_C;
    if (rtrim > TRIM_CAP_C) rtrim = TRIM_CAP_C;
  end

  assign lsum = 19'(lstat.base_c) + ltrim;
  assign rsum = 19'(rstat.base_c) + rtrim;

  assign tick_live = s1_kind_r && moving_r;

  always_comb begin
    lcmd_nxt   = '0;
    rcmd_nxt   = '0;
    lhalt_nxt  = 1'b0;
    rhalt_nxt  = 1'b0;
    done_nxt   = 1'b0;
    moving_nxt = moving_r;
    if (!s1_kind_r) begin
      moving_nxt = 1'b1;
    end else if (tick_live) begin
      lcmd_nxt  = lsum[CmdW-1:0];
      rcmd_nxt  = rsum[CmdW-1:0];
      lhalt_nxt = lstat.halt;
      rhalt_nxt = rstat.halt;
      if (lstat.halt && rstat.halt) begin
        done_nxt   = 1'b1;
        moving_nxt = 1'b0;
      end
    end
    active_nxt = moving_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpc_r          <= CPC_RESET;
      max_rpm_r      <= MAX_RPM_RESET;
      stop_thr_r     <= STOP_THR_RESET;
      left_target_r  <= '0;
      right_target_r <= '0;
      heading_r      <= '0;
      moving_r       <= 1'b0;
      s1_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COUNTS_PER_CELL: cpc_r      <= cfg_wdata[15:0];
          REG_MAX_RPM:         max_rpm_r  <= cfg_wdata[9:0];
          REG_STOP_THRESHOLD:  stop_thr_r <= cfg_wdata[15:0];
          default: ;  // unused index: drop the write
        endcase
      end
      if (in_take) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r  <= 1'b1;
        moving_r <= moving_nxt;
        if (!s1_kind_r) begin
          left_target_r  <= left_target_nxt;
          right_target_r <= right_target_nxt;
          heading_r      <= s1_goal_r;
        end
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r  <= in_ch.kind;
      s1_cell_r  <= in_ch.cell_count;
      s1_left_r  <= in_ch.left_count;
      s1_right_r <= in_ch.right_count;
      s1_yaw_r   <= in_ch.yaw_now;
      s1_goal_r  <= in_ch.heading_goal;
    end
    if (adv) begin
      lcmd_r   <= lcmd_nxt;
      rcmd_r   <= rcmd_nxt;
      lhalt_r  <= lhalt_nxt;
      rhalt_r  <= rhalt_nxt;
      done_r   <= done_nxt;
      active_r <= active_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.left_cmd   = lcmd_r;
  assign out_ch.right_cmd  = rcmd_r;
  assign out_ch.left_halt  = lhalt_r;
  assign out_ch.right_halt = rhalt_r;
  assign out_ch.done_res   = done_r;
  assign out_ch.active     = active_r;

endmodule

`default_nettype wire

[tb/sv/dtrim_tb_pkg.sv]
// dtrim_tb_pkg: word and result types, constants and the expected-result scoreboard
// for the distance drive testbench. Depends on dtrim_pkg for the register indexes.
`default_nettype none

package dtrim_tb_pkg;

  import dtrim_pkg::*;

  typedef enum logic {WORD_START = 1'b0, WORD_TICK = 1'b1} word_kind_t;

  typedef struct packed {
    word_kind_t         kind;
    logic [3:0]         cell_count;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] yaw_now;
    logic signed [15:0] heading_goal;
  } drive_word_t;

  typedef struct packed {
    logic signed [16:0] left_cmd;
    logic signed [16:0] right_cmd;
    logic               left_halt;
    logic               right_halt;
    logic               done_res;
    logic               active;
  } wheel_result_t;

  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  localparam int DEAD_ZONE   = 50;
  localparam int BANG_SPEED  = 150;
  localparam int CENTI       = 100;     // rpm to hundredths of rpm
  localparam int HALF_TURN   = 18000;
  localparam int FULL_TURN   = 36000;
  localparam int TRIM_CEIL   = 10000;   // 100 rpm in hundredths
  localparam int MAX_REPORTS = 40;

  localparam logic [15:0] INIT_CELL_SCALE = 16'd1000;
  localparam logic [9:0]  INIT_RPM_LIMIT  = 10'd200;
  localparam logic [15:0] INIT_HALT_THR   = 16'd20;

  function automatic logic signed [31:0] clip32(longint v);
    if (v > I32_MAX) return I32_MAX[31:0];
    if (v < I32_MIN) return I32_MIN[31:0];
    return v[31:0];
  endfunction

  class dtrim_scoreboard;
    logic [15:0]        cell_scale;
    logic [9:0]         rpm_limit;
    logic [15:0]        halt_thr;
    logic signed [31:0] left_tgt;
    logic signed [31:0] right_tgt;
    logic signed [15:0] yaw_tgt;
    bit                 moving;
    wheel_result_t      want_q[$];
    int                 errors;
    int                 checked;

    function new();
      cell_scale = INIT_CELL_SCALE;
      rpm_limit  = INIT_RPM_LIMIT;
      halt_thr   = INIT_HALT_THR;
      left_tgt   = '0;
      right_tgt  = '0;
      yaw_tgt    = '0;
      moving     = 1'b0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_COUNTS_PER_CELL: cell_scale = data;
        REG_MAX_RPM:         rpm_limit  = data[9:0];
        REG_STOP_THRESHOLD:  halt_thr   = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // bang-bang speed in rpm, clamped to the configured limit
    function int bang(longint err);
      int b;
      if (mag(err) < DEAD_ZONE) b = 0;
      else if (err < 0)         b = -BANG_SPEED;
      else                      b = BANG_SPEED;
      if (b > int'(rpm_limit))  b = int'(rpm_limit);
      if (b < -int'(rpm_limit)) b = -int'(rpm_limit);
      return b;
    endfunction

    // heading error folded into half a turn, sign per the wrap rule
    function int yaw_error(logic signed [15:0] yaw);
      int diff;
      int span;
      int e;
      bit neg;
      diff = int'(yaw) - int'(yaw_tgt);
      span = (diff < 0) ? -diff : diff;
      e = span;
      if (e > HALF_TURN) e = FULL_TURN - e;
      neg = !(diff > 0);
      if (span > HALF_TURN) neg = !neg;
      return neg ? -e : e;
    endfunction

    function void note_word(drive_word_t w);
      longint        lc;
      longint        rc;
      longint        travel;
      longint        el;
      longint        er;
      longint        bl;
      longint        br;
      longint        lcmd;
      longint        rcmd;
      int            e;
      wheel_result_t r;
      r  = '0;
      lc = longint'(w.left_count);
      rc = longint'(w.right_count);
      if (w.kind == WORD_START) begin
        travel    = longint'(w.cell_count) * longint'(cell_scale);
        left_tgt  = clip32(lc + travel);
        right_tgt = clip32(rc + travel);
        yaw_tgt   = w.heading_goal;
        moving    = 1'b1;
      end else if (moving) begin
        el   = longint'(left_tgt) - lc;
        er   = longint'(right_tgt) - rc;
        bl   = longint'(bang(el)) * CENTI;
        br   = longint'(bang(er)) * CENTI;
        e    = yaw_error(w.yaw_now);
        lcmd = bl - e;
        if (lcmd > bl + TRIM_CEIL) lcmd = bl + TRIM_CEIL;
        rcmd = br + e;
        if (rcmd > br + TRIM_CEIL) rcmd = br + TRIM_CEIL;
        r.left_cmd   = lcmd[16:0];
        r.right_cmd  = rcmd[16:0];
        r.left_halt  = mag(el) < longint'(halt_thr);
        r.right_halt = mag(er) < longint'(halt_thr);
        if (r.left_halt && r.right_halt) begin
          r.done_res = 1'b1;
          moving     = 1'b0;
        end
      end
      r.active = moving;
      want_q.push_back(r);
    endfunction

    task report(string what);
      if (errors < MAX_REPORTS) $display("mismatch, result %0d: %s", checked, what);
      errors++;
    endtask

    task check_result(wheel_result_t got);
      wheel_result_t want;
      if (want_q.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = want_q.pop_front();
        if (got.left_cmd !== want.left_cmd)
          report($sformatf("left_cmd %0d, want %0d", got.left_cmd, want.left_cmd));
        if (got.right_cmd !== want.right_cmd)
          report($sformatf("right_cmd %0d, want %0d", got.right_cmd, want.right_cmd));
        if (got.left_halt !== want.left_halt)
          report($sformatf("left_halt %b, want %b", got.left_halt, want.left_halt));
        if (got.right_halt !== want.right_halt)
          report($sformatf("right_halt %b, want %b", got.right_halt, want.right_halt));
        if (got.done_res !== want.done_res)
          report($sformatf("done_res %b, want %b", got.done_res, want.done_res));
        if (got.active !== want.active)
          report($sformatf("active %b, want %b", got.active, want.active));
      end
      checked++;
    endtask
  endclass

endpackage

`default_nettype wire

[tb/sv/tb.sv]
// tb: top of the distance drive testbench; drives start and tick words, writes the
// registers between phases and checks every result word. Depends on dtrim_pkg,
// dtrim_tb_pkg, both channel interfaces and distance_drive_heading_trim_core.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtrim_pkg::*;
  import dtrim_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 6;
  localparam int SEG_WORDS    = 215;
  localparam int SEG_COUNT    = 6;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  dtrim_in_if  in_ch();
  dtrim_out_if out_ch();

  distance_drive_heading_trim_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dtrim_scoreboard sb;
  int tx_idle_pct = 22;
  int rx_idle_pct = 73;
  int hold_asked  = 0;
  int words_sent  = 0;
  int cycles      = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random backpressure, plus a long hold whenever one is asked for
  initial begin
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    wheel_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.left_cmd   = out_ch.left_cmd;
      got.right_cmd  = out_ch.right_cmd;
      got.left_halt  = out_ch.left_halt;
      got.right_halt = out_ch.right_halt;
      got.done_res   = out_ch.done_res;
      got.active     = out_ch.active;
      sb.check_result(got);
    end
  end

  function automatic drive_word_t mk_word(word_kind_t k, logic [3:0] cells,
                                          logic signed [31:0] lc, logic signed [31:0] rc,
                                          logic signed [15:0] yaw, logic signed [15:0] goal);
    drive_word_t w;
    w.kind         = k;
    w.cell_count   = cells;
    w.left_count   = lc;
    w.right_count  = rc;
    w.yaw_now      = yaw;
    w.heading_goal = goal;
    return w;
  endfunction

  function automatic logic signed [31:0] pick_count();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return clip32(I32_MAX - longint'($urandom_range(0, 20000)));
      1:       return clip32(I32_MIN + longint'($urandom_range(0, 20000)));
      2, 3, 4: return int'($urandom_range(0, 2000000)) - 1000000;
      default: return r;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_heading();
    logic [15:0] r;
    r = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) < 8) return 16'(int'($urandom_range(0, 36000)) - HALF_TURN);
    return r;
  endfunction

  // yaw around the goal, with the wrap boundaries hit often
  function automatic logic signed [15:0] pick_yaw(logic signed [15:0] goal);
    int v;
    case ($urandom_range(0, 9))
      0:       v = goal + HALF_TURN;
      1:       v = goal - HALF_TURN;
      2:       v = goal + HALF_TURN + 1;
      3:       v = goal - HALF_TURN - 1;
      4:       v = int'($urandom_range(0, 65535));
      5:       v = int'($urandom_range(0, 36000)) - HALF_TURN;
      default: v = goal + int'($urandom_range(0, 2000)) - 1000;
    endcase
    return v[15:0];
  endfunction

  // encoder position on the way to the target; the last steps land near it
  function automatic logic signed [31:0] toward(longint from_pos, longint to_pos,
                                                int k, int steps);
    longint pos;
    int     slack;
    slack = (int'(sb.halt_thr) > 2000) ? 2000 : int'(sb.halt_thr);
    if (k < steps) begin
      pos = from_pos + (to_pos - from_pos) * k / steps
            + longint'(int'($urandom_range(0, 400)) - 200);
    end else begin
      case ($urandom_range(0, 4))
        0:       pos = to_pos - slack;
        1:       pos = to_pos + slack - 1;
        2:       pos = to_pos;
        default: pos = to_pos + longint'(int'($urandom_range(0, 2 * slack)) - slack);
      endcase
    end
    return clip32(pos);
  endfunction

  // offer one word; valid stays high after acceptance unless the next word idles first
  task automatic send_word(input drive_word_t w);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= w.kind;
    in_ch.cell_count   <= w.cell_count;
    in_ch.left_count   <= w.left_count;
    in_ch.right_count  <= w.right_count;
    in_ch.yaw_now      <= w.yaw_now;
    in_ch.heading_goal <= w.heading_goal;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic drive_move();
    drive_word_t w;
    longint      from_l;
    longint      from_r;
    int          steps;
    logic [3:0]  cells;
    cells = 4'($urandom_range(0, 15));
    w = mk_word(WORD_START, cells, pick_count(), pick_count(), pick_heading(),
                pick_heading());
    send_word(w);
    from_l = w.left_count;
    from_r = w.right_count;
    steps  = $urandom_range(1, 8);
    for (int k = 1; k <= steps + 3 && sb.moving; k++) begin
      cells = 4'($urandom_range(0, 15));
      w = mk_word(WORD_TICK, cells, toward(from_l, sb.left_tgt, k, steps),
                  toward(from_r, sb.right_tgt, k, steps), pick_yaw(sb.yaw_tgt),
                  pick_heading());
      send_word(w);
    end
  endtask

  // drop valid and wait until every expected word is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_setting(logic [15:0] scale, logic [9:0] rpm, logic [15:0] thr);
    write_reg(REG_COUNTS_PER_CELL, scale);
    write_reg(REG_MAX_RPM, CfgDataW'(rpm));
    write_reg(REG_STOP_THRESHOLD, thr);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          seg_base;
    logic [15:0] scale;
    logic [9:0]  rpm;
    logic [15:0] thr;
    logic [3:0]  cells;
    sb = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= 1'b0;
    in_ch.cell_count   <= '0;
    in_ch.left_count   <= '0;
    in_ch.right_count  <= '0;
    in_ch.yaw_now      <= '0;
    in_ch.heading_goal <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // tick while idle, then a saturating start and huge count errors
    send_word(mk_word(WORD_TICK, 4'd15, 32'sh7FFFFFFF, 32'sh80000000, 16'sh7FFF, 16'sh8000));
    send_word(mk_word(WORD_START, 4'd15, 32'sh7FFFFFFF, 32'sh80000000, 16'sd0, 16'sd18000));
    send_word(mk_word(WORD_TICK, 4'd0, 32'sh80000000, 32'sh7FFFFFFF, -16'sd18000, 16'sd0));
    // deadband and stop-threshold edges, heading exactly and just past half a turn
    send_word(mk_word(WORD_START, 4'd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0));
    send_word(mk_word(WORD_TICK, 4'd0, 32'sd49, -32'sd50, 16'sd18000, 16'sd0));
    send_word(mk_word(WORD_TICK, 4'd0, -32'sd49, 32'sd50, -16'sd18000, 16'sd0));
    send_word(mk_word(WORD_TICK, 4'd0, 32'sd19, 32'sd20, 16'sd18001, 16'sd0));
    send_word(mk_word(WORD_TICK, 4'd0, -32'sd20, -32'sd19, -16'sd18001, 16'sd0));
    send_word(mk_word(WORD_TICK, 4'd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0));
    send_word(mk_word(WORD_TICK, 4'd0, 32'sd0, 32'sd0, 16'sd100, 16'sd0));
    // restart during a move, wrapped heading error
    send_word(mk_word(WORD_START, 4'd3, -32'sd5000, 32'sd7000, 16'sd0, -16'sd17000));
    send_word(mk_word(WORD_START, 4'd1, 32'sd100, 32'sd100, 16'sd0, 16'sd17000));
    send_word(mk_word(WORD_TICK, 4'd0, 32'sd1100, 32'sd0, -16'sd17000, 16'sd0));
    send_word(mk_word(WORD_TICK, 4'd0, 32'sd1100, 32'sd1081, 16'sh7FFF, 16'sd0));
    // headings far outside a half turn
    send_word(mk_word(WORD_START, 4'd15, 32'sd0, 32'sd0, 16'sd0, 16'sh7FFF));
    send_word(mk_word(WORD_TICK, 4'd0, 32'sd0, 32'sd30000, 16'sh8000, 16'sd0));
    send_word(mk_word(WORD_TICK, 4'd0, 32'sd14950, 32'sd14951, 16'sh7FFF, 16'sd0));
    send_word(mk_word(WORD_START, 4'd0, 32'sd0, 32'sd0, 16'sd0, 16'sh8000));
    send_word(mk_word(WORD_TICK, 4'd0, 32'sd0, 32'sd0, 16'sh7FFF, 16'sd0));

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      settle();
      case (seg)
        0:       begin scale = 16'd800;   rpm = 10'd120;  thr = 16'd35;    end
        1:       begin scale = 16'd1;     rpm = 10'd0;    thr = 16'd0;     end
        2:       begin scale = 16'd65535; rpm = 10'd1000; thr = 16'd65535; end
        4:       begin scale = 16'd1000;  rpm = 10'd150;  thr = 16'd50;    end
        default: begin
          scale = 16'($urandom_range(1, 65535));
          rpm   = 10'($urandom_range(0, 1000));
          thr   = 16'($urandom_range(0, 3000));
        end
      endcase
      apply_setting(scale, rpm, thr);
      tx_idle_pct = (seg < 2) ? 22 : (seg < 4) ? 73 : 0;
      rx_idle_pct = (seg < 2) ? 73 : (seg < 4) ? 22 : 0;
      // long receiver stall while words keep coming
      if (seg == 0 || seg == 4) hold_asked++;
      seg_base = words_sent;
      while (words_sent - seg_base < SEG_WORDS) begin
        if ($urandom_range(99) < 15) begin
          cells = 4'($urandom_range(0, 15));
          send_word(mk_word($urandom_range(0, 1) ? WORD_TICK : WORD_START, cells,
                            $urandom, $urandom, pick_yaw(pick_heading()), pick_heading()));
        end else begin
          drive_move();
        end
      end
    end

    settle();
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/core/dtrim_pkg.sv
rtl/core/dtrim_in_if.sv
rtl/core/dtrim_out_if.sv
rtl/core/dtrim_wheel.sv
rtl/core/dtrim_heading.sv
rtl/core/distance_drive_heading_trim_core.sv
tb/sv/dtrim_tb_pkg.sv
tb/sv/tb.sv
